/* hdl/tld_pkg.sv */
// Package for the tank level debouncer: level codes, per-tank state and result types,
// and the level classification and error counter update functions.
// No dependencies.
`default_nettype none

package tld_pkg;

   // widths of the item fields
   localparam int unsigned TANK_W  = 2;
   localparam int unsigned LEVEL_W = 4;
   localparam int unsigned COUNT_W = 8;
   localparam int unsigned DELAY_W = 8;

   // defaults
   localparam int unsigned NUM_TANKS_DEFAULT = 4;
   localparam logic [DELAY_W-1:0] RESET_DELAY = 8'd10;

   // level codes
   localparam logic [LEVEL_W-1:0] LV_NONE        = 4'd0;
   localparam logic [LEVEL_W-1:0] LV_LOW         = 4'd1;
   localparam logic [LEVEL_W-1:0] LV_MID         = 4'd2;
   localparam logic [LEVEL_W-1:0] LV_HIGH        = 4'd3;
   localparam logic [LEVEL_W-1:0] LV_ERR_LOW     = 4'd4;
   localparam logic [LEVEL_W-1:0] LV_ERR_HIGH    = 4'd5;
   localparam logic [LEVEL_W-1:0] LV_ERR_COMPLEX = 4'd6;
   localparam logic [LEVEL_W-1:0] LV_ERR_OVF_LOW = 4'd7;
   localparam logic [LEVEL_W-1:0] LV_OVF         = 4'd8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // debounce and error state of one tank
   typedef struct packed {
      logic [LEVEL_W-1:0] last_sample;
      logic [LEVEL_W-1:0] accepted_level;
      logic [DELAY_W-1:0] countdown;
      logic [COUNT_W-1:0] low_errors;
      logic [COUNT_W-1:0] complex_errors;
      logic [COUNT_W-1:0] high_errors;
      logic [COUNT_W-1:0] overflow_errors;
   } tank_state_type;

   // result of one item, tank index excluded
   typedef struct packed {
      logic [LEVEL_W-1:0] stable_level;
      logic               level_changed;
      logic               tank_full;
      logic               level_error;
      logic [COUNT_W-1:0] low_error_count;
      logic [COUNT_W-1:0] complex_error_count;
      logic [COUNT_W-1:0] high_error_count;
      logic [COUNT_W-1:0] overflow_count;
   } result_type;

   function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
      return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
   endfunction

   // err_low through ovf
   function automatic logic is_error_code(input logic [LEVEL_W-1:0] lv);
      return (lv >= LV_ERR_LOW) && (lv <= LV_OVF);
   endfunction

   // counter update when the stable level moves to lv
   function automatic tank_state_type count_errors(input tank_state_type s,
                                                   input logic [LEVEL_W-1:0] lv);
      tank_state_type r;
      r = s;
      unique case (lv)
         LV_ERR_LOW, LV_ERR_OVF_LOW: r.low_errors      = sat_inc(s.low_errors);
         LV_ERR_COMPLEX:             r.complex_errors  = sat_inc(s.complex_errors);
         LV_ERR_HIGH:                r.high_errors     = sat_inc(s.high_errors);
         LV_OVF:                     r.overflow_errors = sat_inc(s.overflow_errors);
         LV_HIGH: begin
            r.high_errors    = '0;
            r.complex_errors = '0;
         end
         default: begin
         end
      endcase
      if ((lv != LV_ERR_LOW) && (lv != LV_ERR_OVF_LOW)) begin
         r.low_errors = '0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

/* hdl/tld_tank_state.sv */
// Per-tank debounce state and error counters with their registered update.
// Depends on tld_pkg.
`default_nettype none

module tld_tank_state #(
   parameter int unsigned NUM_TANKS = tld_pkg::NUM_TANKS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         upd_en,
   input  wire logic [tld_pkg::TANK_W-1:0]   tank,
   input  wire logic [tld_pkg::LEVEL_W-1:0]  level,
   input  wire logic [tld_pkg::DELAY_W-1:0]  detect_delay,
   output tld_pkg::result_type               result
);

   localparam int unsigned IDX_W = (NUM_TANKS > 1) ? $clog2(NUM_TANKS) : 1;

   // state of one tank after reset: everything zero, countdown at the default delay
   localparam tld_pkg::tank_state_type STATE_RESET = tld_pkg::tank_state_type'({
      {(2 * tld_pkg::LEVEL_W){1'b0}}, tld_pkg::RESET_DELAY, {(4 * tld_pkg::COUNT_W){1'b0}}});

   tld_pkg::tank_state_type state_ff [NUM_TANKS];
   tld_pkg::tank_state_type state_in [NUM_TANKS];
   tld_pkg::tank_state_type cur;
   tld_pkg::tank_state_type nxt;
   logic [IDX_W-1:0]        idx;
   logic                    in_range;
   logic                    changed;
   logic                    err;

   assign in_range = 32'(tank) < NUM_TANKS;
   assign idx      = IDX_W'(tank);

   // debounce step for the addressed tank
   always_comb begin
      cur     = state_ff[idx];
      nxt     = cur;
      changed = 1'b0;
      if (cur.last_sample != level) begin
         nxt.last_sample = level;
         nxt.countdown   = detect_delay;
      end else if (cur.countdown != '0) begin
         nxt.countdown = cur.countdown - tld_pkg::DELAY_W'(1);
      end else if (cur.accepted_level != level) begin
         nxt                = tld_pkg::count_errors(cur, level);
         nxt.accepted_level = level;
         changed            = 1'b1;
      end
   end

   // result fields, all zero for a tank that does not exist
   always_comb begin
      err    = tld_pkg::is_error_code(nxt.accepted_level);
      result = '0;
      if (in_range) begin
         result.stable_level        = nxt.accepted_level;
         result.level_changed       = changed;
         result.tank_full           = err || (nxt.accepted_level == tld_pkg::LV_HIGH);
         result.level_error         = err;
         result.low_error_count     = nxt.low_errors;
         result.complex_error_count = nxt.complex_errors;
         result.high_error_count    = nxt.high_errors;
         result.overflow_count      = nxt.overflow_errors;
      end
   end

   // write back the addressed entry
   always_comb begin
      state_in = state_ff;
      if (upd_en && in_range) begin
         state_in[idx] = nxt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TANKS; i++) begin
            state_ff[i] <= STATE_RESET;
         end
      end else begin
         state_ff <= state_in;
      end
   end

   // a stable level change needs a settled sample and an expired countdown
   a_change_needs_settle: assert property (@(posedge clock) disable iff (reset)
      upd_en && result.level_changed |-> cur.countdown == '0 && cur.last_sample == level)
      else $error("level change without settled countdown");

   // moving to high clears the high and complex counters
   a_high_clears: assert property (@(posedge clock) disable iff (reset)
      upd_en && result.level_changed && level == tld_pkg::LV_HIGH
      |-> result.high_error_count == '0 && result.complex_error_count == '0)
      else $error("high level did not clear counters");

   // an absent tank gives an all-zero result
   a_absent_tank: assert property (@(posedge clock) disable iff (reset)
      upd_en && !in_range |-> result == '0)
      else $error("absent tank produced a nonzero result");

endmodule

`default_nettype wire

/* hdl/tank_level_debounce_error_count.sv */
// Top level of the tank level debouncer: input register, per-tank state update,
// result register and the detect delay register. Depends on tld_pkg, tld_tank_state.
//
// One item is taken per clock cycle with no gaps while rsp_ready is high; each item is
// held in the input register and its result then in the result register. The rate is
// set by the per-tank read-modify-write of the debounce state, done combinationally
// from the input register into the result register, so an item for the same tank
// in the next cycle sees the updated state. A stalled result register holds one item
// while the input register holds the next. The detect delay is written through
// csr_wr_en/csr_wr_data and is used at the next countdown reload.
`default_nettype none

module tank_level_debounce_error_count #(
   parameter int unsigned NUM_TANKS = tld_pkg::NUM_TANKS_DEFAULT
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // configuration
   input  wire logic                         csr_wr_en,
   input  wire logic [tld_pkg::DELAY_W-1:0]  csr_wr_data,
   // input items
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [tld_pkg::TANK_W-1:0]   req_tank,
   input  wire logic [tld_pkg::LEVEL_W-1:0]  req_sampled_level,
   // result items
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [tld_pkg::TANK_W-1:0]        rsp_tank_out,
   output logic [tld_pkg::LEVEL_W-1:0]       rsp_stable_level,
   output logic                              rsp_level_changed,
   output logic                              rsp_tank_full,
   output logic                              rsp_level_error,
   output logic [tld_pkg::COUNT_W-1:0]       rsp_low_error_count,
   output logic [tld_pkg::COUNT_W-1:0]       rsp_complex_error_count,
   output logic [tld_pkg::COUNT_W-1:0]       rsp_high_error_count,
   output logic [tld_pkg::COUNT_W-1:0]       rsp_overflow_count
);

   logic [tld_pkg::DELAY_W-1:0] delay_ff;
   logic                        in_valid_ff, in_valid_in;
   logic [tld_pkg::TANK_W-1:0]  in_tank_ff;
   logic [tld_pkg::LEVEL_W-1:0] in_level_ff;
   logic                        out_valid_ff, out_valid_in;
   logic [tld_pkg::TANK_W-1:0]  out_tank_ff;
   tld_pkg::result_type         out_result_ff;
   tld_pkg::result_type         result;
   logic                        advance;
   logic                        req_take;
   logic                        upd_en;

   // handshake and pipeline advance
   assign advance   = !out_valid_ff || rsp_ready;
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;
   assign upd_en    = in_valid_ff && advance;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = upd_en ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);
   end

   // detect delay register
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= tld_pkg::RESET_DELAY;
      end else if (csr_wr_en) begin
         delay_ff <= csr_wr_data;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input item register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_tank_ff  <= req_tank;
         in_level_ff <= req_sampled_level;
      end
   end

   // per-tank state and update
   tld_tank_state #(
      .NUM_TANKS (NUM_TANKS)
   ) u_tank_state (
      .clock        (clock),
      .reset        (reset),
      .upd_en       (upd_en),
      .tank         (in_tank_ff),
      .level        (in_level_ff),
      .detect_delay (delay_ff),
      .result       (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (upd_en) begin
         out_tank_ff   <= in_tank_ff;
         out_result_ff <= result;
      end
   end

   assign rsp_valid               = out_valid_ff;
   assign rsp_tank_out            = out_tank_ff;
   assign rsp_stable_level        = out_result_ff.stable_level;
   assign rsp_level_changed       = out_result_ff.level_changed;
   assign rsp_tank_full           = out_result_ff.tank_full;
   assign rsp_level_error         = out_result_ff.level_error;
   assign rsp_low_error_count     = out_result_ff.low_error_count;
   assign rsp_complex_error_count = out_result_ff.complex_error_count;
   assign rsp_high_error_count    = out_result_ff.high_error_count;
   assign rsp_overflow_count      = out_result_ff.overflow_count;

   // an empty result register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

   // a held item moves on when the result register drains
   a_item_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance |=> out_valid_ff)
      else $error("item lost between input and result register");

   // an error level always reports full
   a_error_is_full: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_result_ff.level_error |-> out_result_ff.tank_full)
      else $error("error level without tank full");

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for tank_level_debounce_error_count: per-tank debounce and
// saturating error counters, checked item by item against an in-bench prediction.
// Depends on tld_pkg and the tank_level_debounce_error_count RTL.
`timescale 1ns / 1ps

module testbench;

   // codes outside the defined level set
   localparam logic [tld_pkg::LEVEL_W-1:0] LV_UNDEF_FIRST = 4'd9;
   localparam logic [tld_pkg::LEVEL_W-1:0] LV_UNDEF_LAST  = 4'd15;

   localparam int QUIET_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 80;

   typedef struct packed {
      logic [tld_pkg::TANK_W-1:0]  tank;
      logic [tld_pkg::LEVEL_W-1:0] level;
   } sensor_sample_type;

   typedef struct packed {
      logic [tld_pkg::TANK_W-1:0] tank;
      tld_pkg::result_type        res;
   } level_report_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_wr_en = 1'b0;
   logic [tld_pkg::DELAY_W-1:0]  csr_wr_data = '0;
   logic                         req_valid = 1'b0;
   logic                         req_ready;
   logic [tld_pkg::TANK_W-1:0]   req_tank = '0;
   logic [tld_pkg::LEVEL_W-1:0]  req_sampled_level = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 1'b0;
   logic [tld_pkg::TANK_W-1:0]   rsp_tank_out;
   logic [tld_pkg::LEVEL_W-1:0]  rsp_stable_level;
   logic                         rsp_level_changed;
   logic                         rsp_tank_full;
   logic                         rsp_level_error;
   logic [tld_pkg::COUNT_W-1:0]  rsp_low_error_count;
   logic [tld_pkg::COUNT_W-1:0]  rsp_complex_error_count;
   logic [tld_pkg::COUNT_W-1:0]  rsp_high_error_count;
   logic [tld_pkg::COUNT_W-1:0]  rsp_overflow_count;

   // stimulus and expectations
   sensor_sample_type pending_samples[$];
   level_report_type  expected_reports[$];
   sensor_sample_type next_sample;
   level_report_type  oldest_report;

   // predicted state of the block
   tld_pkg::tank_state_type     tank_model[tld_pkg::NUM_TANKS_DEFAULT];
   logic [tld_pkg::DELAY_W-1:0] delay_model;

   int  sender_idle_pct = 0;
   int  receiver_idle_pct = 0;
   bit  hold_request = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_left = 0;
   bit  req_taken = 1'b0;
   int  quiet_cycles = 0;
   int  results_seen = 0;
   int  mismatch_count = 0;

   tank_level_debounce_error_count u_top (
      .clock                   (clock),
      .reset                   (reset),
      .csr_wr_en               (csr_wr_en),
      .csr_wr_data             (csr_wr_data),
      .req_valid               (req_valid),
      .req_ready               (req_ready),
      .req_tank                (req_tank),
      .req_sampled_level       (req_sampled_level),
      .rsp_valid               (rsp_valid),
      .rsp_ready               (rsp_ready),
      .rsp_tank_out            (rsp_tank_out),
      .rsp_stable_level        (rsp_stable_level),
      .rsp_level_changed       (rsp_level_changed),
      .rsp_tank_full           (rsp_tank_full),
      .rsp_level_error         (rsp_level_error),
      .rsp_low_error_count     (rsp_low_error_count),
      .rsp_complex_error_count (rsp_complex_error_count),
      .rsp_high_error_count    (rsp_high_error_count),
      .rsp_overflow_count      (rsp_overflow_count)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // counter step that sticks at the top
   function automatic logic [tld_pkg::COUNT_W-1:0] bump_count(
      input logic [tld_pkg::COUNT_W-1:0] c);
      return (c == {tld_pkg::COUNT_W{1'b1}}) ? c : c + 8'd1;
   endfunction

   // debounce one sample and return the report the block should give for it
   function automatic level_report_type debounce_sample(input sensor_sample_type smp);
      tld_pkg::tank_state_type st;
      level_report_type        rep;
      logic                    moved;
      logic                    faulty;
      st = tank_model[smp.tank];
      moved = 1'b0;
      if (st.last_sample != smp.level) begin
         st.last_sample = smp.level;
         st.countdown = delay_model;
      end else if (st.countdown != '0) begin
         st.countdown = st.countdown - 8'd1;
      end else if (st.accepted_level != smp.level) begin
         moved = 1'b1;
         st.accepted_level = smp.level;
         case (smp.level)
            tld_pkg::LV_ERR_LOW, tld_pkg::LV_ERR_OVF_LOW:
               st.low_errors = bump_count(st.low_errors);
            tld_pkg::LV_ERR_COMPLEX: st.complex_errors = bump_count(st.complex_errors);
            tld_pkg::LV_ERR_HIGH:    st.high_errors = bump_count(st.high_errors);
            tld_pkg::LV_OVF:         st.overflow_errors = bump_count(st.overflow_errors);
            tld_pkg::LV_HIGH: begin
               st.high_errors = '0;
               st.complex_errors = '0;
            end
            default: ;
         endcase
         if (smp.level != tld_pkg::LV_ERR_LOW && smp.level != tld_pkg::LV_ERR_OVF_LOW) begin
            st.low_errors = '0;
         end
      end
      tank_model[smp.tank] = st;
      faulty = (st.accepted_level >= tld_pkg::LV_ERR_LOW)
               && (st.accepted_level <= tld_pkg::LV_OVF);
      rep.tank = smp.tank;
      rep.res.stable_level = st.accepted_level;
      rep.res.level_changed = moved;
      rep.res.tank_full = faulty || (st.accepted_level == tld_pkg::LV_HIGH);
      rep.res.level_error = faulty;
      rep.res.low_error_count = st.low_errors;
      rep.res.complex_error_count = st.complex_errors;
      rep.res.high_error_count = st.high_errors;
      rep.res.overflow_count = st.overflow_errors;
      return rep;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at result %0d: %0s", results_seen, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%0s got %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic push_sample(input logic [tld_pkg::TANK_W-1:0] tank,
                              input logic [tld_pkg::LEVEL_W-1:0] level);
      sensor_sample_type smp;
      smp.tank = tank;
      smp.level = level;
      pending_samples.push_back(smp);
   endtask

   // block until nothing is queued, offered or outstanding
   task automatic wait_drained();
      @(posedge clock);
      while (pending_samples.size() != 0 || req_valid || expected_reports.size() != 0) begin
         @(posedge clock);
      end
   endtask

   // write the detect delay while idle, after the pipeline has emptied
   task automatic write_detect_delay(input logic [tld_pkg::DELAY_W-1:0] value);
      repeat (3) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      delay_model = value;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_idle_pct = receiver_pct;
   endtask

   // interleaved runs of repeated codes per tank, with some stray samples mixed in
   task automatic queue_level_runs(input int count, input int tank_span, input int delay);
      logic [tld_pkg::LEVEL_W-1:0] run_level[tld_pkg::NUM_TANKS_DEFAULT];
      int                          run_left[tld_pkg::NUM_TANKS_DEFAULT];
      int                          i;
      int                          t;
      for (t = 0; t < tld_pkg::NUM_TANKS_DEFAULT; t++) begin
         run_left[t] = 0;
         run_level[t] = '0;
      end
      for (i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            push_sample(tld_pkg::TANK_W'($urandom), tld_pkg::LEVEL_W'($urandom));
         end else begin
            t = $urandom_range(0, tank_span);
            if (run_left[t] == 0) begin
               run_level[t] = ($urandom_range(0, 3) == 0)
                              ? tld_pkg::LEVEL_W'($urandom)
                              : tld_pkg::LEVEL_W'($urandom_range(0, 8));
               run_left[t] = $urandom_range(0, 1) ? $urandom_range(1, delay + 3) : delay + 2;
            end
            push_sample(tld_pkg::TANK_W'(t), run_level[t]);
            run_left[t]--;
         end
      end
   endtask

   // with no delay, drive the low counter of tank 0 up to its ceiling while
   // tank 1 steps through the upper error counters
   task automatic queue_counter_saturation();
      logic [tld_pkg::LEVEL_W-1:0] low_cycle[2];
      logic [tld_pkg::LEVEL_W-1:0] upper_cycle[3];
      int                          low_left;
      int                          upper_left;
      int                          low_pos;
      int                          upper_pos;
      low_cycle = '{tld_pkg::LV_ERR_LOW, tld_pkg::LV_ERR_OVF_LOW};
      upper_cycle = '{tld_pkg::LV_ERR_HIGH, tld_pkg::LV_ERR_COMPLEX, tld_pkg::LV_OVF};
      low_left = 260;
      upper_left = 40;
      low_pos = 0;
      upper_pos = 0;
      while (low_left > 0 || upper_left > 0) begin
         if ($urandom_range(0, 9) == 0) begin
            push_sample(tld_pkg::TANK_W'($urandom_range(2, 3)), tld_pkg::LEVEL_W'($urandom));
         end else if (upper_left == 0 || (low_left > 0 && $urandom_range(0, 3) == 0)) begin
            push_sample(2'd0, low_cycle[low_pos]);
            push_sample(2'd0, low_cycle[low_pos]);
            low_pos = 1 - low_pos;
            low_left--;
         end else begin
            push_sample(2'd1, upper_cycle[upper_pos]);
            push_sample(2'd1, upper_cycle[upper_pos]);
            upper_pos = (upper_pos + 1) % 3;
            upper_left--;
         end
      end
   endtask

   // input driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_samples.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            next_sample = pending_samples.pop_front();
            req_tank <= next_sample.tank;
            req_sampled_level <= next_sample.level;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off on request
   always @(negedge clock) begin
      if (hold_request && !hold_done) begin
         hold_left = HOLD_OFF_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // monitor: check results, predict accepted items, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_reports.size() == 0) begin
               report_mismatch($sformatf("result for tank %0d with nothing expected",
                                         rsp_tank_out));
            end else begin
               oldest_report = expected_reports.pop_front();
               check_field("tank_out", 8'(rsp_tank_out), 8'(oldest_report.tank));
               check_field("stable_level", 8'(rsp_stable_level),
                           8'(oldest_report.res.stable_level));
               check_field("level_changed", 8'(rsp_level_changed),
                           8'(oldest_report.res.level_changed));
               check_field("tank_full", 8'(rsp_tank_full), 8'(oldest_report.res.tank_full));
               check_field("level_error", 8'(rsp_level_error),
                           8'(oldest_report.res.level_error));
               check_field("low_error_count", rsp_low_error_count,
                           oldest_report.res.low_error_count);
               check_field("complex_error_count", rsp_complex_error_count,
                           oldest_report.res.complex_error_count);
               check_field("high_error_count", rsp_high_error_count,
                           oldest_report.res.high_error_count);
               check_field("overflow_count", rsp_overflow_count,
                           oldest_report.res.overflow_count);
            end
            results_seen++;
         end
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            next_sample.tank = req_tank;
            next_sample.level = req_sampled_level;
            expected_reports.push_back(debounce_sample(next_sample));
         end
         if ((rsp_valid && rsp_ready) || req_taken) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   // stimulus sequence
   initial begin
      int i;
      int t;
      logic [tld_pkg::DELAY_W-1:0] chosen_delay;
      delay_model = tld_pkg::RESET_DELAY;
      for (t = 0; t < tld_pkg::NUM_TANKS_DEFAULT; t++) begin
         tank_model[t] = '0;
         tank_model[t].countdown = tld_pkg::RESET_DELAY;
      end
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // reset delay: an undefined code on the top tank is accepted on its twelfth tick
      for (i = 0; i < 12; i++) begin
         push_sample(2'd3, LV_UNDEF_FIRST);
      end
      wait_drained();

      // no delay: each code is accepted on its second tick, walk all counter effects
      write_detect_delay(8'd0);
      push_sample(2'd0, tld_pkg::LV_ERR_LOW);
      push_sample(2'd0, tld_pkg::LV_ERR_LOW);
      push_sample(2'd0, tld_pkg::LV_ERR_OVF_LOW);
      push_sample(2'd0, tld_pkg::LV_ERR_OVF_LOW);
      push_sample(2'd0, tld_pkg::LV_OVF);
      push_sample(2'd0, tld_pkg::LV_OVF);
      push_sample(2'd0, tld_pkg::LV_ERR_COMPLEX);
      push_sample(2'd0, tld_pkg::LV_ERR_COMPLEX);
      push_sample(2'd0, tld_pkg::LV_ERR_HIGH);
      push_sample(2'd0, tld_pkg::LV_ERR_HIGH);
      push_sample(2'd0, tld_pkg::LV_HIGH);
      push_sample(2'd0, tld_pkg::LV_HIGH);
      push_sample(2'd0, LV_UNDEF_LAST);
      push_sample(2'd0, LV_UNDEF_LAST);
      wait_drained();

      // slow sender, busy receiver, with one long receiver hold-off
      set_idling(20, 76);
      hold_request = 1'b1;
      write_detect_delay(8'd10);
      queue_level_runs(150, 3, 10);
      wait_drained();

      // longest delay on two tanks
      write_detect_delay(8'd255);
      queue_level_runs(150, 1, 255);
      wait_drained();

      // idling swapped: low counter pushed to saturation
      set_idling(76, 20);
      write_detect_delay(8'd0);
      queue_counter_saturation();
      wait_drained();

      chosen_delay = $urandom_range(1, 30);
      write_detect_delay(chosen_delay);
      queue_level_runs(100, 3, chosen_delay);
      wait_drained();

      // no idling on either side
      set_idling(0, 0);
      write_detect_delay(8'd1);
      queue_level_runs(100, 3, 1);
      wait_drained();

      chosen_delay = $urandom_range(2, 6);
      write_detect_delay(chosen_delay);
      queue_level_runs(60, 3, chosen_delay);
      wait_drained();

      // let any stray result show up
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
hdl/tld_pkg.sv
hdl/tld_tank_state.sv
hdl/tank_level_debounce_error_count.sv
sim/testbench.sv
